// ===== hdl/rclt_pkg.sv =====
package rclt_pkg;

	localparam int MAX_COORDS = 256;
	localparam int FRAC_BITS  = 16;
	localparam int ADDR_W     = 8;
	localparam int CNT_W      = 9;
	localparam int WGT_W      = FRAC_BITS + 1;
	localparam int CELL_W     = 8;

	localparam logic [0:0] OP_LOAD  = 1'b0;
	localparam logic [0:0] OP_QUERY = 1'b1;

	localparam logic [1:0] AX_X = 2'd0;
	localparam logic [1:0] AX_Y = 2'd1;
	localparam logic [1:0] AX_Z = 2'd2;

	localparam logic [1:0] REG_COUNT_X = 2'd0;
	localparam logic [1:0] REG_COUNT_Y = 2'd1;
	localparam logic [1:0] REG_COUNT_Z = 2'd2;
	localparam logic [1:0] REG_MODE    = 2'd3;

	localparam logic [1:0] MODE_MEAN    = 2'd0;
	localparam logic [1:0] MODE_TRILIN  = 2'd1;
	localparam logic [1:0] MODE_FIRST   = 2'd2;
	localparam logic [1:0] MODE_NEAREST = 2'd3;

	localparam logic [WGT_W-1:0] W_ONE  = WGT_W'(1) << FRAC_BITS;
	localparam logic [WGT_W-1:0] W_HALF = WGT_W'(1) << (FRAC_BITS - 1);

	typedef struct packed {
		logic       clear;
		logic       init_axis;
		logic       srch_step;
		logic       bound_lo;
		logic       bound_hi;
		logic       fetch_lo;
		logic       fetch_hi;
		logic       div_start;
		logic       div_step;
		logic       save_axis;
		logic       mul_step;
		logic       emit;
		logic [1:0] axis;
	} ctl_t;

	typedef struct packed {
		logic srch_done;
		logic div_done;
		logic outside;
		logic mul_done;
	} sts_t;

endpackage

// ===== hdl/rclt_ctrl.sv =====
module rclt_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           go,
	input  rclt_pkg::sts_t sts,
	output rclt_pkg::ctl_t ctl,
	output logic           busy
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_INIT  = 4'd1;
	localparam logic [3:0] S_BLO   = 4'd2;
	localparam logic [3:0] S_BHI   = 4'd3;
	localparam logic [3:0] S_CHK   = 4'd4;
	localparam logic [3:0] S_SRCH  = 4'd5;
	localparam logic [3:0] S_FLO   = 4'd6;
	localparam logic [3:0] S_FHI   = 4'd7;
	localparam logic [3:0] S_DSTA  = 4'd8;
	localparam logic [3:0] S_DIV   = 4'd9;
	localparam logic [3:0] S_SAVE  = 4'd10;
	localparam logic [3:0] S_MUL   = 4'd11;
	localparam logic [3:0] S_EMIT  = 4'd12;

	logic [3:0] state_q, state_d;
	logic [1:0] axis_q, axis_d;

	always_comb begin
		state_d = state_q;
		axis_d  = axis_q;
		ctl     = '0;
		ctl.axis = axis_q;
		case (state_q)
			S_IDLE: begin
				if (go) begin
					ctl.clear = 1'b1;
					axis_d  = rclt_pkg::AX_X;
					state_d = S_INIT;
				end
			end
			S_INIT: begin
				ctl.init_axis = 1'b1;
				state_d = S_BLO;
			end
			S_BLO: begin
				ctl.bound_lo = 1'b1;
				state_d = S_BHI;
			end
			S_BHI: begin
				ctl.bound_hi = 1'b1;
				state_d = S_CHK;
			end
			S_CHK: begin
				if (sts.outside) state_d = S_EMIT;
				else state_d = S_SRCH;
			end
			S_SRCH: begin
				ctl.srch_step = 1'b1;
				if (sts.srch_done) state_d = S_FLO;
			end
			S_FLO: begin
				ctl.fetch_lo = 1'b1;
				state_d = S_FHI;
			end
			S_FHI: begin
				ctl.fetch_hi = 1'b1;
				state_d = S_DSTA;
			end
			S_DSTA: begin
				ctl.div_start = 1'b1;
				state_d = S_DIV;
			end
			S_DIV: begin
				ctl.div_step = 1'b1;
				if (sts.div_done) state_d = S_SAVE;
			end
			S_SAVE: begin
				ctl.save_axis = 1'b1;
				if (axis_q == rclt_pkg::AX_Z) begin
					state_d = S_MUL;
				end else begin
					axis_d  = axis_q + 2'd1;
					state_d = S_INIT;
				end
			end
			S_MUL: begin
				ctl.mul_step = 1'b1;
				if (sts.mul_done) state_d = S_EMIT;
			end
			S_EMIT: begin
				ctl.emit = 1'b1;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			axis_q  <= rclt_pkg::AX_X;
		end else begin
			state_q <= state_d;
			axis_q  <= axis_d;
		end
	end

	assign busy = (state_q != S_IDLE);

endmodule

// ===== hdl/rclt_dpath.sv =====
module rclt_dpath (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               load_en,
	input  logic [1:0]                         axis,
	input  logic [rclt_pkg::ADDR_W-1:0]        slot,
	input  logic signed [31:0]                 coord_value,
	input  logic                               query_en,
	input  logic signed [31:0]                 point_x,
	input  logic signed [31:0]                 point_y,
	input  logic signed [31:0]                 point_z,
	input  logic [rclt_pkg::CNT_W-1:0]         cnt_x,
	input  logic [rclt_pkg::CNT_W-1:0]         cnt_y,
	input  logic [rclt_pkg::CNT_W-1:0]         cnt_z,
	input  logic [1:0]                         mode,
	input  rclt_pkg::ctl_t                     ctl,
	output rclt_pkg::sts_t                     sts,
	output logic                               done,
	output logic                               found,
	output logic [rclt_pkg::CELL_W-1:0]        cell_x,
	output logic [rclt_pkg::CELL_W-1:0]        cell_y,
	output logic [rclt_pkg::CELL_W-1:0]        cell_z,
	output logic [8*rclt_pkg::WGT_W-1:0]       weights
);

	localparam int AW = rclt_pkg::ADDR_W;
	localparam int CW = rclt_pkg::CNT_W;
	localparam int FB = rclt_pkg::FRAC_BITS;
	localparam int WW = rclt_pkg::WGT_W;

	logic signed [31:0] mem_x [rclt_pkg::MAX_COORDS];
	logic signed [31:0] mem_y [rclt_pkg::MAX_COORDS];
	logic signed [31:0] mem_z [rclt_pkg::MAX_COORDS];

	logic signed [31:0] px_q, py_q, pz_q;
	logic [AW-1:0]      raddr;
	logic signed [31:0] rd_q;

	logic [CW-1:0]      cnt;
	logic signed [31:0] pnt;
	logic [CW-1:0]      lo_q;
	logic [CW-1:0]      scan_q;
	logic [CW-1:0]      ridx_q;
	logic               rv_q;
	logic               below;
	logic               stop;
	logic [CW-1:0]      lo_nxt;
	logic               outside_q;
	logic [AW-1:0]      cell_q;
	logic signed [31:0] clo_q;
	logic signed [32:0] size_q, diff_q;
	logic [WW-1:0]      tfix_q;
	logic               tconst_q;

	logic [32:0]        rem_q;
	logic [32:0]        dvs_q;
	logic [FB-1:0]      quo_q;
	logic [4:0]         dcnt_q;

	logic [WW-1:0]      tx_q, ty_q, tz_q;
	logic [AW-1:0]      cx_q, cy_q, cz_q;
	logic [3:0]         mcnt_q;
	logic [WW-1:0]      ab_q;
	logic [WW-1:0]      w_q [8];

	always_comb begin
		case (ctl.axis)
			rclt_pkg::AX_X: begin cnt = cnt_x; pnt = px_q; end
			rclt_pkg::AX_Y: begin cnt = cnt_y; pnt = py_q; end
			default:        begin cnt = cnt_z; pnt = pz_q; end
		endcase
		if (cnt > CW'(rclt_pkg::MAX_COORDS)) cnt = CW'(rclt_pkg::MAX_COORDS);
	end

	always_comb begin
		raddr = '0;
		if (ctl.init_axis)     raddr = '0;
		else if (ctl.bound_lo) raddr = AW'(cnt - CW'(1));
		else if (ctl.srch_step) raddr = scan_q[AW-1:0];
		else if (ctl.fetch_lo) raddr = cell_q;
		else                   raddr = cell_q + AW'(1);
	end

	always_ff @(posedge clk) begin
		if (load_en) begin
			case (axis)
				rclt_pkg::AX_X: mem_x[slot] <= coord_value;
				rclt_pkg::AX_Y: mem_y[slot] <= coord_value;
				rclt_pkg::AX_Z: mem_z[slot] <= coord_value;
				default: ;
			endcase
		end
		case (ctl.axis)
			rclt_pkg::AX_X: rd_q <= mem_x[raddr];
			rclt_pkg::AX_Y: rd_q <= mem_y[raddr];
			default:        rd_q <= mem_z[raddr];
		endcase
	end

	// scan from entry 0, stop at the first entry not below the point
	assign below  = rd_q < pnt;
	assign stop   = rv_q && !below;
	assign lo_nxt = (rv_q && below) ? ridx_q : lo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outside_q <= 1'b0;
			rv_q      <= 1'b0;
			lo_q      <= '0;
			scan_q    <= '0;
			ridx_q    <= '0;
		end else begin
			if (ctl.clear) outside_q <= 1'b0;
			if (ctl.init_axis) begin
				if (cnt < CW'(2)) outside_q <= 1'b1;
				lo_q   <= '0;
				scan_q <= '0;
				rv_q   <= 1'b0;
			end
			if (ctl.bound_lo) begin
				if (pnt < rd_q) outside_q <= 1'b1;
			end
			if (ctl.bound_hi) begin
				if (pnt > rd_q) outside_q <= 1'b1;
			end
			if (ctl.srch_step) begin
				lo_q   <= lo_nxt;
				rv_q   <= scan_q < cnt;
				ridx_q <= scan_q;
				if (scan_q < cnt) scan_q <= scan_q + CW'(1);
			end
		end
	end

	assign sts.srch_done = ctl.srch_step && (stop || scan_q >= cnt);
	assign sts.outside   = outside_q;

	logic [AW-1:0] lo_cell;
	always_comb begin
		lo_cell = lo_nxt[AW-1:0];
		if (lo_nxt + CW'(1) >= cnt) lo_cell = AW'(cnt - CW'(2));
	end

	always_ff @(posedge clk) begin
		if (sts.srch_done) cell_q <= lo_cell;
		if (ctl.fetch_hi) begin
			clo_q  <= rd_q;
			diff_q <= 33'(pnt) - 33'(rd_q);
		end
		if (ctl.div_start) begin
			size_q <= 33'(rd_q) - 33'(clo_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dcnt_q <= '0;
		end else if (ctl.div_start) begin
			dcnt_q <= 5'(FB + 1);
		end else if (ctl.div_step && dcnt_q != 5'd0) begin
			dcnt_q <= dcnt_q - 5'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.div_step) begin
			if (dcnt_q == 5'(FB + 1)) begin
				tconst_q <= 1'b1;
				if (size_q[32] || size_q == '0 || diff_q[32] || diff_q == '0)
					tfix_q <= '0;
				else if (diff_q >= size_q)
					tfix_q <= rclt_pkg::W_ONE;
				else
					tconst_q <= 1'b0;
				rem_q <= diff_q;
				dvs_q <= size_q;
				quo_q <= '0;
			end else if (dcnt_q != 5'd0) begin
				if ({rem_q, 1'b0} >= {1'b0, dvs_q}) begin
					rem_q <= 33'({rem_q, 1'b0} - {1'b0, dvs_q});
					quo_q <= {quo_q[FB-2:0], 1'b1};
				end else begin
					rem_q <= {rem_q[31:0], 1'b0};
					quo_q <= {quo_q[FB-2:0], 1'b0};
				end
			end
		end
	end
	// after loading, the first compare tests diff*2 against size; diff < size so rem stays under size

	assign sts.div_done = ctl.div_step && dcnt_q == 5'd1;

	logic [WW-1:0] tval;
	assign tval = tconst_q ? tfix_q : WW'(quo_q);

	always_ff @(posedge clk) begin
		if (ctl.save_axis) begin
			case (ctl.axis)
				rclt_pkg::AX_X: begin tx_q <= tval; cx_q <= cell_q; end
				rclt_pkg::AX_Y: begin ty_q <= tval; cy_q <= cell_q; end
				default:        begin tz_q <= tval; cz_q <= cell_q; end
			endcase
		end
	end

	// 16 steps: even step forms ab for corner k, odd step multiplies by c
	logic [2:0]    corner;
	logic          phase;
	logic [WW-1:0] fa, fb, fc, mop_a, mop_b;
	logic [2*WW-1:0] prod;
	logic [WW-1:0] prnd;

	assign corner = mcnt_q[3:1];
	assign phase  = mcnt_q[0];

	always_comb begin
		logic hx, hy, hz;
		hx = (corner == 3'd1) || (corner == 3'd2) || (corner == 3'd5) || (corner == 3'd6);
		hy = (corner == 3'd2) || (corner == 3'd3) || (corner == 3'd6) || (corner == 3'd7);
		hz = corner[2];
		fa = hx ? tx_q : rclt_pkg::W_ONE - tx_q;
		fb = hy ? ty_q : rclt_pkg::W_ONE - ty_q;
		fc = hz ? tz_q : rclt_pkg::W_ONE - tz_q;
		mop_a = phase ? ab_q : fa;
		mop_b = phase ? fc : fb;
		prod  = mop_a * mop_b;
		prnd  = WW'((prod + (2*WW)'(rclt_pkg::W_HALF)) >> FB);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mcnt_q <= '0;
		end else if (ctl.clear) begin
			mcnt_q <= '0;
		end else if (ctl.mul_step) begin
			mcnt_q <= mcnt_q + 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.mul_step) begin
			if (!phase) ab_q <= prnd;
			else w_q[corner] <= prnd;
		end
	end

	assign sts.mul_done = ctl.mul_step && mcnt_q == 4'd15;

	logic [2:0] near_c;
	always_comb begin
		logic hx, hy;
		hx = tx_q >= rclt_pkg::W_HALF;
		hy = ty_q >= rclt_pkg::W_HALF;
		near_c = hy ? (hx ? 3'd2 : 3'd3) : (hx ? 3'd1 : 3'd0);
		if (tz_q >= rclt_pkg::W_HALF) near_c = near_c + 3'd4;
	end

	always_ff @(posedge clk) begin
		if (query_en) begin
			px_q <= point_x;
			py_q <= point_y;
			pz_q <= point_z;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= ctl.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.emit) begin
			found  <= !outside_q;
			cell_x <= outside_q ? '0 : cx_q;
			cell_y <= outside_q ? '0 : cy_q;
			cell_z <= outside_q ? '0 : cz_q;
			for (int k = 0; k < 8; k++) begin
				if (outside_q) weights[k*WW +: WW] <= '0;
				else begin
					case (mode)
						rclt_pkg::MODE_MEAN:
							weights[k*WW +: WW] <= rclt_pkg::W_ONE >> 3;
						rclt_pkg::MODE_TRILIN:
							weights[k*WW +: WW] <= w_q[k];
						rclt_pkg::MODE_FIRST:
							weights[k*WW +: WW] <= (k == 0) ? rclt_pkg::W_ONE : '0;
						default:
							weights[k*WW +: WW] <= (3'(k) == near_c) ? rclt_pkg::W_ONE : '0;
					endcase
				end
			end
		end
	end

endmodule

// ===== hdl/rectilinear_cell_locate_trilinear.sv =====
// Rectilinear grid cell locator. Load transactions (opcode 0) write one
// coordinate and return nothing. A query transaction walks the x, y and z
// tables in turn: two bound reads, a front-to-back scan that stops at the
// first entry not below the point, and a restoring division per axis, then
// sixteen shared-multiplier steps for the corner weights. A point outside the
// extent of an axis ends the query early with found low. The result appears
// for exactly one cycle with done high and cannot be held off by the
// receiver.
module rectilinear_cell_locate_trilinear (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic                              opcode,
	input  logic [1:0]                        axis,
	input  logic [7:0]                        slot,
	input  logic signed [31:0]                coord_value,
	input  logic signed [31:0]                point_x,
	input  logic signed [31:0]                point_y,
	input  logic signed [31:0]                point_z,
	input  logic                              cfg_we,
	input  logic [1:0]                        cfg_index,
	input  logic [8:0]                        cfg_data,
	output logic                              done,
	output logic                              found,
	output logic [7:0]                        cell_x,
	output logic [7:0]                        cell_y,
	output logic [7:0]                        cell_z,
	output logic [16:0]                       weight_0,
	output logic [16:0]                       weight_1,
	output logic [16:0]                       weight_2,
	output logic [16:0]                       weight_3,
	output logic [16:0]                       weight_4,
	output logic [16:0]                       weight_5,
	output logic [16:0]                       weight_6,
	output logic [16:0]                       weight_7
);

	localparam int WW = rclt_pkg::WGT_W;

	logic [8:0] cnt_x_q, cnt_y_q, cnt_z_q;
	logic [1:0] mode_q;
	rclt_pkg::ctl_t ctl;
	rclt_pkg::sts_t sts;
	logic accept, load_en, query_en;
	logic [8*WW-1:0] weights;

	assign accept   = start && !busy;
	assign load_en  = accept && opcode == rclt_pkg::OP_LOAD;
	assign query_en = accept && opcode == rclt_pkg::OP_QUERY;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_x_q <= '0;
			cnt_y_q <= '0;
			cnt_z_q <= '0;
			mode_q  <= rclt_pkg::MODE_TRILIN;
		end else if (cfg_we) begin
			case (cfg_index)
				rclt_pkg::REG_COUNT_X: cnt_x_q <= cfg_data;
				rclt_pkg::REG_COUNT_Y: cnt_y_q <= cfg_data;
				rclt_pkg::REG_COUNT_Z: cnt_z_q <= cfg_data;
				default:               mode_q  <= cfg_data[1:0];
			endcase
		end
	end

	rclt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (query_en),
		.sts    (sts),
		.ctl    (ctl),
		.busy   (busy)
	);

	rclt_dpath u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.load_en     (load_en),
		.axis        (axis),
		.slot        (slot),
		.coord_value (coord_value),
		.query_en    (query_en),
		.point_x     (point_x),
		.point_y     (point_y),
		.point_z     (point_z),
		.cnt_x       (cnt_x_q),
		.cnt_y       (cnt_y_q),
		.cnt_z       (cnt_z_q),
		.mode        (mode_q),
		.ctl         (ctl),
		.sts         (sts),
		.done        (done),
		.found       (found),
		.cell_x      (cell_x),
		.cell_y      (cell_y),
		.cell_z      (cell_z),
		.weights     (weights)
	);

	assign weight_0 = weights[0*WW +: WW];
	assign weight_1 = weights[1*WW +: WW];
	assign weight_2 = weights[2*WW +: WW];
	assign weight_3 = weights[3*WW +: WW];
	assign weight_4 = weights[4*WW +: WW];
	assign weight_5 = weights[5*WW +: WW];
	assign weight_6 = weights[6*WW +: WW];
	assign weight_7 = weights[7*WW +: WW];

endmodule

// ===== hdl/rclt_checker.sv =====
module rclt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        opcode,
	input logic        done,
	input logic        found,
	input logic [7:0]  cell_x,
	input logic [16:0] weight_0
);

	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && opcode |=> busy)
		else $error("query transaction did not raise busy");

	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && !opcode |=> !busy)
		else $error("load transaction raised busy");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result held more than one cycle");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !found |-> cell_x == 8'd0 && weight_0 == 17'd0)
		else $error("not-found result carries data");

endmodule

bind rectilinear_cell_locate_trilinear rclt_checker u_rclt_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.start    (start),
	.busy     (busy),
	.opcode   (opcode),
	.done     (done),
	.found    (found),
	.cell_x   (cell_x),
	.weight_0 (weight_0)
);
